FILE: hw/rtl/bsg_pkg.sv
// ----------------------------------------------------------------------------
// Block signature package
// Shared constants and MD5 tables for the block signature generator.
// ----------------------------------------------------------------------------
`default_nettype none
package bsg_pkg;

	localparam int unsigned LengthBitsDefault = 32;

	localparam logic [15:0] WEAK_MASK = 16'hffff;
	localparam int unsigned HEADER_WORDS = 12 / 4;
	localparam int unsigned ENTRY_WORDS = 20 / 4;

	localparam logic [31:0] BS_RESET = 32'd1024;

	// configuration register indexes
	localparam logic [1:0] REG_BLOCK_SIZE = 2'd0;
	localparam logic [1:0] REG_TOTAL_LEN = 2'd1;
	localparam logic [1:0] REG_CHAR_OFFSET = 2'd2;

	// op codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_ENTRY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [31:0] MD5_IV0 = 32'h67452301;
	localparam logic [31:0] MD5_IV1 = 32'hefcdab89;
	localparam logic [31:0] MD5_IV2 = 32'h98badcfe;
	localparam logic [31:0] MD5_IV3 = 32'h10325476;

	// MD5 additive constants
	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	// MD5 rotate amounts, indexed by round group and round mod 4
	function automatic logic [4:0] md5_rot(input logic [5:0] i);
		logic [4:0] r;
		case ({i[5:4], i[1:0]})
			4'd0: r = 5'd7;  4'd1: r = 5'd12; 4'd2: r = 5'd17; 4'd3: r = 5'd22;
			4'd4: r = 5'd5;  4'd5: r = 5'd9;  4'd6: r = 5'd14; 4'd7: r = 5'd20;
			4'd8: r = 5'd4;  4'd9: r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
			4'd12: r = 5'd6; 4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] bswap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bsg_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one read of the same address per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module bsg_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wr_data,
	output logic [Width-1:0]              rd_data
);
	logic [Width-1:0] mem_q [Depth];

	// write one entry and read the addressed entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wr_data;
		end
		rd_data <= mem_q[addr];
	end
endmodule
`default_nettype wire

FILE: hw/rtl/block_signature_generator.sv
// A start request runs the divider (one divider cycle per quotient bit) before its
// first header word; an error result is presented in the cycle after acceptance.
// A data byte stalls the input through ST_FEED and ST_WR; filling a 64-byte chunk
// adds 64 rounds, each a RAM read state and a round state, plus the chain add. A
// block end adds up to 16 padding words and one or two compressions ahead of its
// five entry words. A new request is taken only in ST_IDLE. Reset: async.
// ----------------------------------------------------------------------------
// Block signature generator
// Header words, weak sums and MD5 digests for fixed-size blocks of one file.
// ----------------------------------------------------------------------------
`default_nettype none
module block_signature_generator
	import bsg_pkg::*;
#(
	parameter int unsigned LengthBits = LengthBitsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	// requests
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [7:0]  data_byte,
	// results
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      word,
	output logic [1:0]       kind,
	output logic             last,
	output logic             file_done
);
	localparam int unsigned LB = LengthBits;
	localparam int unsigned DivCntW = $clog2(LB + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_HDR, ST_FEED, ST_WR, ST_RND_RD, ST_RND, ST_ADD,
		ST_PAD, ST_ENT, ST_ERR
	} state_t;

	state_t state_q;

	// configuration registers
	logic [31:0] seg_len_q;
	logic [31:0] total_length_q;
	logic [7:0]  char_offset_q;

	// block state
	logic [15:0]   sum_a_q, sum_c_q;
	logic [31:0]   h_q [4];
	logic [31:0]   va_q, vb_q, vc_q, vd_q;
	logic [LB-1:0] blk_cnt_q;
	logic [LB-1:0] left_q;
	logic [LB-1:0] offs_q;
	logic          started_q;

	// sequencer state
	logic [5:0]    rnd_q;
	logic [1:0]    pad_q;     // 0 data chunk, 1 padded first, 2 length chunk
	logic          fin_q;     // running final compressions of a block
	logic [31:0]   wbuf_q;    // word being assembled for the RAM
	logic [3:0]    wcnt_q;    // word being written in padding
	logic [2:0]    oidx_q;
	logic          done_q;
	logic [7:0]    byte_q;

	// header division
	logic [LB-1:0]      quo_q, rem_q, div_d_q;
	logic [DivCntW-1:0] dcnt_q;

	// effective lengths
	logic [LB-1:0] bs_eff, tot_m, remain, next_left;
	assign tot_m = total_length_q[LB-1:0];
	assign bs_eff = (seg_len_q[LB-1:0] == '0) ? LB'(1) : seg_len_q[LB-1:0];
	assign remain = tot_m - offs_q;
	assign next_left = (offs_q >= tot_m) ? '0 : ((remain < bs_eff) ? remain : bs_eff);

	// message RAM
	logic        ram_we;
	logic [3:0]  ram_addr;
	logic [31:0] ram_wd, ram_rd;

	bsg_ram #(.Width(32), .Depth(16)) u_msg (
		.clk(clk), .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_wd), .rd_data(ram_rd)
	);

	// round index into message
	logic [3:0] g_idx;
	always_comb begin
		case (rnd_q[5:4])
			2'd0: g_idx = rnd_q[3:0];
			2'd1: g_idx = 4'(5 * rnd_q[3:0] + 1);
			2'd2: g_idx = 4'(3 * rnd_q[3:0] + 5);
			default: g_idx = 4'(7 * rnd_q[3:0]);
		endcase
	end

	// length of the block in bits, for the length chunk
	logic [63:0] bitlen;
	assign bitlen = {29'd0, 32'(blk_cnt_q), 3'd0};

	// message word source: RAM in data chunks, synthesized in padding
	logic [5:0]    pos;
	assign pos = blk_cnt_q[5:0];
	logic [5:0]    pos_inc;
	assign pos_inc = pos + 6'd1;
	logic [31:0]   m_word;
	always_comb begin
		m_word = ram_rd;
		if (pad_q == 2'd2) begin
			if (g_idx == 4'd14) m_word = bitlen[31:0];
			else if (g_idx == 4'd15) m_word = bitlen[63:32];
			else m_word = '0;
		end else if (pad_q == 2'd1 && pos < 6'd56) begin
			if (g_idx == 4'd14) m_word = bitlen[31:0];
			else if (g_idx == 4'd15) m_word = bitlen[63:32];
		end
	end

	// shared round unit
	logic [31:0] f_val, sum_r, rot_r;
	logic [4:0]  sh;
	always_comb begin
		case (rnd_q[5:4])
			2'd0: f_val = (vb_q & vc_q) | (~vb_q & vd_q);
			2'd1: f_val = (vd_q & vb_q) | (~vd_q & vc_q);
			2'd2: f_val = vb_q ^ vc_q ^ vd_q;
			default: f_val = vc_q ^ (vb_q | ~vd_q);
		endcase
		sh = md5_rot(rnd_q);
		sum_r = va_q + f_val + md5_k(rnd_q) + m_word;
		rot_r = (sum_r << sh) | (sum_r >> (6'd32 - {1'b0, sh}));
	end

	// RAM port control
	logic [1:0] bsel;
	assign bsel = pos[1:0];
	logic [31:0] merged;
	always_comb begin
		merged = (bsel == 2'd0) ? 32'd0 : wbuf_q;
		merged[8*bsel +: 8] = byte_q;
	end
	always_comb begin
		ram_we = 1'b0;
		ram_addr = g_idx;
		ram_wd = merged;
		if (state_q == ST_WR) begin
			ram_we = 1'b1;
			ram_addr = pos[5:2];
		end else if (state_q == ST_PAD) begin
			ram_we = 1'b1;
			ram_addr = wcnt_q;
			ram_wd = '0;
			if (wcnt_q == pos[5:2]) begin
				ram_wd = (bsel == 2'd0) ? 32'd0 : wbuf_q;
				ram_wd[8*bsel +: 8] = 8'h80;
			end
		end else if (state_q == ST_ADD || state_q == ST_RND_RD) begin
			ram_addr = (state_q == ST_ADD) ? 4'd0 : g_idx;
		end
	end

	// output word
	always_comb begin
		word = '0;
		kind = KIND_ERROR;
		last = 1'b1;
		case (state_q)
			ST_HDR: begin
				kind = KIND_HEADER;
				last = (oidx_q == 3'(HEADER_WORDS - 1));
				case (oidx_q)
					3'd0: word = 32'(quo_q) + ((rem_q != '0) ? 32'd1 : 32'd0);
					3'd1: word = 32'(bs_eff);
					default: word = 32'(rem_q);
				endcase
			end
			ST_ENT: begin
				kind = KIND_ENTRY;
				last = (oidx_q == 3'(ENTRY_WORDS - 1));
				case (oidx_q)
					3'd0: word = {sum_a_q, sum_c_q};
					3'd1: word = bswap32(h_q[0]);
					3'd2: word = bswap32(h_q[1]);
					3'd3: word = bswap32(h_q[2]);
					default: word = bswap32(h_q[3]);
				endcase
			end
			default: word = '0;
		endcase
	end
	assign file_done = done_q;
	assign out_valid = (state_q == ST_HDR) || (state_q == ST_ENT) || (state_q == ST_ERR);
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	logic [15:0] a_next;
	assign a_next = WEAK_MASK & (sum_a_q + 16'(byte_q) + 16'(char_offset_q));

	// trial subtract, one guard bit above the shifted remainder
	logic [LB+1:0] dtrial;
	assign dtrial = {1'b0, rem_q, quo_q[LB-1]} - {2'b00, div_d_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seg_len_q <= BS_RESET;
			total_length_q <= '0;
			char_offset_q <= '0;
			sum_a_q <= '0; sum_c_q <= '0;
			h_q[0] <= MD5_IV0; h_q[1] <= MD5_IV1; h_q[2] <= MD5_IV2; h_q[3] <= MD5_IV3;
			blk_cnt_q <= '0; left_q <= '0; offs_q <= '0; started_q <= 1'b0;
			rnd_q <= '0; pad_q <= '0; fin_q <= 1'b0; wbuf_q <= '0; wcnt_q <= '0;
			oidx_q <= '0; done_q <= 1'b0; byte_q <= '0;
			va_q <= '0; vb_q <= '0; vc_q <= '0; vd_q <= '0;
			quo_q <= '0; rem_q <= '0; div_d_q <= '0; dcnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// take configuration writes
					if (cfg_valid) begin
						case (cfg_index)
							REG_BLOCK_SIZE: seg_len_q <= cfg_data;
							REG_TOTAL_LEN: total_length_q <= cfg_data;
							REG_CHAR_OFFSET: char_offset_q <= cfg_data[7:0];
							default: ;
						endcase
					end
					if (in_valid) begin
						byte_q <= data_byte;
						oidx_q <= '0;
						if (op == OP_START) begin
							// restart block and divide total by block size
							sum_a_q <= '0; sum_c_q <= '0;
							h_q[0] <= MD5_IV0; h_q[1] <= MD5_IV1;
							h_q[2] <= MD5_IV2; h_q[3] <= MD5_IV3;
							blk_cnt_q <= '0; offs_q <= '0; started_q <= 1'b1;
							quo_q <= tot_m; rem_q <= '0; div_d_q <= bs_eff;
							dcnt_q <= DivCntW'(LB);
							state_q <= ST_DIV;
						end else if (!started_q || left_q == '0) begin
							done_q <= started_q;
							state_q <= ST_ERR;
						end else begin
							state_q <= ST_FEED;
						end
					end
				end
				ST_DIV: begin
					// one quotient bit per cycle
					if (dtrial[LB+1]) begin
						rem_q <= {rem_q[LB-2:0], quo_q[LB-1]};
						quo_q <= {quo_q[LB-2:0], 1'b0};
					end else begin
						rem_q <= dtrial[LB-1:0];
						quo_q <= {quo_q[LB-2:0], 1'b1};
					end
					dcnt_q <= dcnt_q - DivCntW'(1);
					if (dcnt_q == DivCntW'(1)) begin
						left_q <= next_left;
						done_q <= (next_left == '0);
						state_q <= ST_HDR;
					end
				end
				ST_HDR, ST_ENT: begin
					if (!out_stall) begin
						oidx_q <= oidx_q + 3'd1;
						if (last) begin
							state_q <= ST_IDLE;
							if (state_q == ST_ENT) begin
								sum_a_q <= '0; sum_c_q <= '0;
								h_q[0] <= MD5_IV0; h_q[1] <= MD5_IV1;
								h_q[2] <= MD5_IV2; h_q[3] <= MD5_IV3;
								blk_cnt_q <= '0;
							end
						end
					end
				end
				ST_ERR: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				ST_FEED: begin
					// update weak sums; the byte goes into the message word in ST_WR
					sum_a_q <= a_next;
					sum_c_q <= sum_c_q + a_next;
					state_q <= ST_WR;
				end
				ST_WR: begin
					wbuf_q <= merged;
					blk_cnt_q <= blk_cnt_q + LB'(1);
					offs_q <= offs_q + LB'(1);
					left_q <= left_q - LB'(1);
					if (pos == 6'd63) begin
						pad_q <= 2'd0;
						fin_q <= (left_q == LB'(1));
						va_q <= h_q[0]; vb_q <= h_q[1]; vc_q <= h_q[2]; vd_q <= h_q[3];
						rnd_q <= '0;
						state_q <= ST_RND_RD;
					end else if (left_q == LB'(1)) begin
						// padding starts at the word that takes the marker
						wcnt_q <= pos_inc[5:2];
						fin_q <= 1'b1;
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					// write 0x80 marker and clear rest of chunk
					wcnt_q <= wcnt_q + 4'd1;
					if (wcnt_q == 4'd15) begin
						pad_q <= 2'd1;
						va_q <= h_q[0]; vb_q <= h_q[1]; vc_q <= h_q[2]; vd_q <= h_q[3];
						rnd_q <= '0;
						state_q <= ST_RND_RD;
					end
				end
				ST_RND_RD: state_q <= ST_RND;
				ST_RND: begin
					// one MD5 round
					va_q <= vd_q;
					vd_q <= vc_q;
					vc_q <= vb_q;
					vb_q <= vb_q + rot_r;
					rnd_q <= rnd_q + 6'd1;
					state_q <= (rnd_q == 6'd63) ? ST_ADD : ST_RND_RD;
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + va_q; h_q[1] <= h_q[1] + vb_q;
					h_q[2] <= h_q[2] + vc_q; h_q[3] <= h_q[3] + vd_q;
					va_q <= h_q[0] + va_q; vb_q <= h_q[1] + vb_q;
					vc_q <= h_q[2] + vc_q; vd_q <= h_q[3] + vd_q;
					rnd_q <= '0;
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (pad_q == 2'd0) begin
						// full chunk ended the block: marker in a fresh chunk
						wcnt_q <= '0;
						state_q <= ST_PAD;
					end else if (pad_q == 2'd1 && pos >= 6'd56) begin
						pad_q <= 2'd2;
						state_q <= ST_RND_RD;
					end else begin
						left_q <= next_left;
						done_q <= (next_left == '0);
						oidx_q <= '0;
						state_q <= ST_ENT;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// no request taken in the round state while a block is being compressed
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND) |-> in_stall) else $error("request taken during rounds");
	// round counter advances by one per round
	a_rnd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND && rnd_q != 6'd63) |=> (rnd_q == $past(rnd_q) + 6'd1))
		else $error("round counter skipped");
	// an error result never carries a header or entry word
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_ERROR) |-> (word == 32'd0 && last))
		else $error("bad error result");
`endif
endmodule
`default_nettype wire
